// ===== design/bpa_pkg.sv =====
// Package for the buddy page allocator: types, request and status codes, defaults.
// Used by buddy_page_allocator_core and tb_buddy_page_allocator_core; depends on nothing else.
package bpa_pkg;

    localparam int NUM_PAGES_DEF  = 4096;
    localparam int NUM_ORDERS_DEF = 11;
    localparam int ORD_W          = 4;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_ALLOC = 2'd1;
    localparam logic [1:0] FUNC_FREE  = 2'd2;

    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_OOM = 2'd1;
    localparam logic [1:0] STAT_BAD = 2'd2;

    // Per-page bookkeeping word held in the metadata memory.
    typedef struct packed {
        logic             is_free;
        logic [ORD_W-1:0] order;
        logic [ORD_W-1:0] ceil;
    } meta_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_K,
        S_ADD_CHK,
        S_AL_FIND,
        S_AL_SPLIT,
        S_AL_CHK,
        S_RL_RD,
        S_RL_CHK,
        S_RL_LOOP,
        S_RL_BCHK,
        S_UL_RD,
        S_UL_WR,
        S_PB,
        S_PB2,
        S_PF,
        S_PF2,
        S_DONE
    } state_t;

endpackage

// ===== design/bpa_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing; instanced by buddy_page_allocator_core for all page state.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/buddy_page_allocator_core.sv =====
// Buddy page allocator: one request in, one response out, per-order free lists.
// Requests are handled one at a time: a new request is taken only after the previous
// response has been loaded into the output register.
// After reset the metadata memory is swept clear before requests are taken.
// Depends on bpa_pkg and bpa_ram.
module buddy_page_allocator_core #(
    parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
    parameter int NUM_ORDERS = bpa_pkg::NUM_ORDERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Bits from LSB: func[1:0], order[5:2], first_page[17:6], end_page[30:18], zero pad.
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Bits from LSB: status[1:0], blk_head[13:2], zero pad.
    output logic [15:0] m_axis_tdata
);

    // Page index, link (index or null), and arithmetic widths.
    localparam int PW = $clog2(NUM_PAGES);
    localparam int LW = PW + 1;
    localparam int XW = ((PW > 16) ? PW : 16) + 1;
    localparam int KW = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
    localparam int OW = bpa_pkg::ORD_W;
    localparam int MW = $bits(bpa_pkg::meta_t);

    localparam logic [LW-1:0] LNULL    = LW'(NUM_PAGES);
    localparam logic [XW-1:0] XPAGES   = XW'(NUM_PAGES);
    localparam logic [OW-1:0] ORD_LAST = OW'(NUM_ORDERS - 1);

    // Request fields.
    logic [1:0]  in_func;
    logic [3:0]  in_order;
    logic [11:0] in_first;
    logic [12:0] in_end;

    assign in_func  = s_axis_tdata[1:0];
    assign in_order = s_axis_tdata[5:2];
    assign in_first = s_axis_tdata[17:6];
    assign in_end   = s_axis_tdata[30:18];

    bpa_pkg::state_t state_reg, state_next;
    bpa_pkg::state_t ret_reg, ret_next;

    logic [1:0]    op_reg, op_next;
    logic [OW-1:0] k_reg, k_next;
    logic [OW-1:0] uk_reg, uk_next;
    logic [OW-1:0] want_reg, want_next;
    logic [OW-1:0] cur_ceil_reg, cur_ceil_next;
    logic [OW-1:0] cur_ord_reg, cur_ord_next;
    logic [PW-1:0] p_reg, p_next;
    logic [PW-1:0] pg_reg, pg_next;
    logic [PW-1:0] u_reg, u_next;
    logic [LW-1:0] t_reg, t_next;
    logic [XW-1:0] base_reg, base_next;
    logic [XW-1:0] end_reg, end_next;
    logic [PW-1:0] clr_reg, clr_next;

    bpa_pkg::meta_t pm_reg, pm_next;
    logic           mw_en_reg, mw_en_next;
    logic [PW-1:0]  mw_addr_reg, mw_addr_next;
    bpa_pkg::meta_t mw_data_reg, mw_data_next;

    logic [1:0]  res_status_reg, res_status_next;
    logic [11:0] res_page_reg, res_page_next;
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [11:0] out_page_reg;
    logic        out_load;

    logic [LW-1:0] head_reg [NUM_ORDERS];
    logic [LW-1:0] head_next [NUM_ORDERS];
    logic [LW-1:0] tail_reg [NUM_ORDERS];
    logic [LW-1:0] tail_next [NUM_ORDERS];

    // Memory ports.
    logic           meta_we;
    logic [PW-1:0]  meta_waddr, meta_raddr;
    bpa_pkg::meta_t meta_wdata, meta_rdata;
    logic           nx_we, pv_we;
    logic [PW-1:0]  nx_waddr, pv_waddr, link_raddr;
    logic [LW-1:0]  nx_wdata, pv_wdata, nx_rdata, pv_rdata;

    // Free flag, current order and merge ceiling of every page.
    bpa_ram #(.WIDTH(MW), .DEPTH(NUM_PAGES)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    // Forward links of the free lists.
    bpa_ram #(.WIDTH(LW), .DEPTH(NUM_PAGES)) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr (link_raddr),
        .rdata (nx_rdata)
    );

    // Backward links of the free lists.
    bpa_ram #(.WIDTH(LW), .DEPTH(NUM_PAGES)) u_prev_ram (
        .clk   (clk),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .raddr (link_raddr),
        .rdata (pv_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpa_pkg::S_CLEAR;
            ret_reg       <= bpa_pkg::S_IDLE;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            mw_en_reg     <= 1'b0;
            for (int i = 0; i < NUM_ORDERS; i++)
            begin
                head_reg[i] <= LNULL;
                tail_reg[i] <= LNULL;
            end
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            clr_reg   <= clr_next;
            mw_en_reg <= mw_en_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        k_reg          <= k_next;
        uk_reg         <= uk_next;
        want_reg       <= want_next;
        cur_ceil_reg   <= cur_ceil_next;
        cur_ord_reg    <= cur_ord_next;
        p_reg          <= p_next;
        pg_reg         <= pg_next;
        u_reg          <= u_next;
        t_reg          <= t_next;
        base_reg       <= base_next;
        end_reg        <= end_next;
        pm_reg         <= pm_next;
        mw_addr_reg    <= mw_addr_next;
        mw_data_reg    <= mw_data_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_page_reg   <= res_page_reg;
        end
    end

    assign s_axis_tready = (state_reg == bpa_pkg::S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_page_reg, out_status_reg};

    // Sequencer: every step issues at most one read per memory and one write per memory.
    always_comb
    begin
        logic          found;
        logic [OW-1:0] fk;
        logic [OW-1:0] kk;
        logic [XW-1:0] rem;
        logic [XW-1:0] bx;
        logic [LW-1:0] lt;

        state_next      = state_reg;
        ret_next        = ret_reg;
        op_next         = op_reg;
        k_next          = k_reg;
        uk_next         = uk_reg;
        want_next       = want_reg;
        cur_ceil_next   = cur_ceil_reg;
        cur_ord_next    = cur_ord_reg;
        p_next          = p_reg;
        pg_next         = pg_reg;
        u_next          = u_reg;
        t_next          = t_reg;
        base_next       = base_reg;
        end_next        = end_reg;
        clr_next        = clr_reg;
        pm_next         = pm_reg;
        mw_en_next      = mw_en_reg;
        mw_addr_next    = mw_addr_reg;
        mw_data_next    = mw_data_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        out_load        = 1'b0;

        meta_we    = 1'b0;
        meta_waddr = pg_reg;
        meta_wdata = pm_reg;
        meta_raddr = p_reg;
        nx_we      = 1'b0;
        nx_waddr   = pg_reg;
        nx_wdata   = LNULL;
        pv_we      = 1'b0;
        pv_waddr   = pg_reg;
        pv_wdata   = LNULL;
        link_raddr = u_reg;

        found = 1'b0;
        fk    = '0;
        kk    = '0;
        rem   = end_reg - base_reg;
        bx    = '0;
        lt    = '0;

        unique case (state_reg)
            bpa_pkg::S_CLEAR:
            begin
                meta_we    = 1'b1;
                meta_waddr = clr_reg;
                meta_wdata = '0;
                clr_next   = clr_reg + PW'(1);
                if (clr_reg == PW'(NUM_PAGES - 1))
                begin
                    state_next = bpa_pkg::S_IDLE;
                end
            end

            bpa_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next         = in_func;
                    res_page_next   = '0;
                    res_status_next = bpa_pkg::STAT_BAD;
                    state_next      = bpa_pkg::S_DONE;
                    case (in_func)
                        bpa_pkg::FUNC_ADD:
                        begin
                            base_next = XW'(in_first);
                            end_next  = (XW'(in_end) > XPAGES) ? XPAGES : XW'(in_end);
                            state_next = bpa_pkg::S_ADD_K;
                        end
                        bpa_pkg::FUNC_ALLOC:
                        begin
                            want_next = in_order;
                            if (32'(in_order) < NUM_ORDERS)
                            begin
                                state_next = bpa_pkg::S_AL_FIND;
                            end
                        end
                        bpa_pkg::FUNC_FREE:
                        begin
                            p_next = PW'(in_first);
                            if (XW'(in_first) < XPAGES)
                            begin
                                state_next = bpa_pkg::S_RL_RD;
                            end
                        end
                        default:
                        begin
                            state_next = bpa_pkg::S_DONE;
                        end
                    endcase
                end
            end

            // Largest aligned block that starts at base and fits below the end.
            bpa_pkg::S_ADD_K:
            begin
                if (base_reg < end_reg)
                begin
                    for (int i = 1; i < NUM_ORDERS; i++)
                    begin
                        if ((base_reg & ((XW'(1) << i) - XW'(1))) == '0 &&
                            rem >= (XW'(1) << i))
                        begin
                            kk = OW'(i);
                        end
                    end
                    k_next     = kk;
                    meta_raddr = base_reg[PW-1:0];
                    pg_next    = base_reg[PW-1:0];
                    state_next = bpa_pkg::S_ADD_CHK;
                end
                else
                begin
                    res_status_next = bpa_pkg::STAT_OK;
                    state_next      = bpa_pkg::S_DONE;
                end
            end

            bpa_pkg::S_ADD_CHK:
            begin
                base_next = base_reg + (XW'(1) << k_reg);
                if (!meta_rdata.is_free)
                begin
                    pm_next    = '{is_free: 1'b1, order: k_reg, ceil: k_reg};
                    ret_next   = bpa_pkg::S_ADD_K;
                    state_next = bpa_pkg::S_PB;
                end
                else
                begin
                    state_next = bpa_pkg::S_ADD_K;
                end
            end

            bpa_pkg::S_AL_FIND:
            begin
                for (int i = 0; i < NUM_ORDERS; i++)
                begin
                    if (!found && OW'(i) >= want_reg && head_reg[i] < LNULL)
                    begin
                        found = 1'b1;
                        fk    = OW'(i);
                    end
                end
                if (!found)
                begin
                    res_status_next = bpa_pkg::STAT_OOM;
                    state_next      = bpa_pkg::S_DONE;
                end
                else
                begin
                    p_next     = head_reg[fk[KW-1:0]][PW-1:0];
                    u_next     = head_reg[fk[KW-1:0]][PW-1:0];
                    uk_next    = fk;
                    k_next     = fk;
                    mw_en_next = 1'b0;
                    ret_next   = bpa_pkg::S_AL_SPLIT;
                    state_next = bpa_pkg::S_UL_RD;
                end
            end

            // Split down to the wanted order, queueing each in-pool upper half that is not yet free.
            bpa_pkg::S_AL_SPLIT:
            begin
                if (k_reg == want_reg)
                begin
                    meta_we         = 1'b1;
                    meta_waddr      = p_reg;
                    meta_wdata      = '{is_free: 1'b0, order: want_reg, ceil: cur_ceil_reg};
                    res_status_next = bpa_pkg::STAT_OK;
                    res_page_next   = 12'(p_reg);
                    state_next      = bpa_pkg::S_DONE;
                end
                else
                begin
                    kk     = k_reg - OW'(1);
                    k_next = kk;
                    bx     = XW'(p_reg) + (XW'(1) << kk);
                    if (bx < XPAGES)
                    begin
                        meta_raddr = bx[PW-1:0];
                        pg_next    = bx[PW-1:0];
                        state_next = bpa_pkg::S_AL_CHK;
                    end
                end
            end

            bpa_pkg::S_AL_CHK:
            begin
                state_next = bpa_pkg::S_AL_SPLIT;
                if (!meta_rdata.is_free)
                begin
                    pm_next    = '{is_free: 1'b1, order: k_reg, ceil: cur_ceil_reg};
                    ret_next   = bpa_pkg::S_AL_SPLIT;
                    state_next = bpa_pkg::S_PB;
                end
            end

            bpa_pkg::S_RL_RD:
            begin
                meta_raddr = p_reg;
                state_next = bpa_pkg::S_RL_CHK;
            end

            bpa_pkg::S_RL_CHK:
            begin
                if (meta_rdata.is_free)
                begin
                    state_next = bpa_pkg::S_DONE;
                end
                else
                begin
                    k_next        = (meta_rdata.order > ORD_LAST) ? ORD_LAST : meta_rdata.order;
                    cur_ord_next  = meta_rdata.order;
                    cur_ceil_next = meta_rdata.ceil;
                    state_next    = bpa_pkg::S_RL_LOOP;
                end
            end

            // Look at the buddy of the current block; merge while allowed.
            bpa_pkg::S_RL_LOOP:
            begin
                pm_next    = '{is_free: 1'b1, order: k_reg, ceil: cur_ceil_reg};
                pg_next    = p_reg;
                state_next = bpa_pkg::S_PF;
                if (k_reg < cur_ceil_reg && k_reg < ORD_LAST)
                begin
                    bx = XW'(p_reg) ^ (XW'(1) << k_reg);
                    if (bx < XPAGES)
                    begin
                        meta_raddr = bx[PW-1:0];
                        pg_next    = bx[PW-1:0];
                        state_next = bpa_pkg::S_RL_BCHK;
                    end
                end
            end

            bpa_pkg::S_RL_BCHK:
            begin
                if (!meta_rdata.is_free || meta_rdata.order != k_reg)
                begin
                    pm_next    = '{is_free: 1'b1, order: k_reg, ceil: cur_ceil_reg};
                    pg_next    = p_reg;
                    state_next = bpa_pkg::S_PF;
                end
                else
                begin
                    u_next     = pg_reg;
                    uk_next    = k_reg;
                    ret_next   = bpa_pkg::S_RL_LOOP;
                    mw_en_next = 1'b1;
                    if (pg_reg < p_reg)
                    begin
                        // The lower buddy becomes the head; retire the old head's entry.
                        mw_addr_next  = p_reg;
                        mw_data_next  = '{is_free: 1'b0, order: cur_ord_reg, ceil: cur_ceil_reg};
                        p_next        = pg_reg;
                        cur_ceil_next = meta_rdata.ceil;
                    end
                    else
                    begin
                        mw_addr_next = pg_reg;
                        mw_data_next = '{is_free: 1'b0, order: k_reg, ceil: meta_rdata.ceil};
                    end
                    cur_ord_next = k_reg + OW'(1);
                    k_next       = k_reg + OW'(1);
                    state_next   = bpa_pkg::S_UL_RD;
                end
            end

            // Unlink page u from list uk.
            bpa_pkg::S_UL_RD:
            begin
                link_raddr = u_reg;
                meta_raddr = u_reg;
                state_next = bpa_pkg::S_UL_WR;
            end

            bpa_pkg::S_UL_WR:
            begin
                if (pv_rdata < LNULL)
                begin
                    nx_we    = 1'b1;
                    nx_waddr = pv_rdata[PW-1:0];
                    nx_wdata = nx_rdata;
                end
                else
                begin
                    head_next[uk_reg[KW-1:0]] = nx_rdata;
                end
                if (nx_rdata < LNULL)
                begin
                    pv_we    = 1'b1;
                    pv_waddr = nx_rdata[PW-1:0];
                    pv_wdata = pv_rdata;
                end
                else
                begin
                    tail_next[uk_reg[KW-1:0]] = pv_rdata;
                end
                if (mw_en_reg)
                begin
                    meta_we    = 1'b1;
                    meta_waddr = mw_addr_reg;
                    meta_wdata = mw_data_reg;
                end
                if (op_reg == bpa_pkg::FUNC_ALLOC)
                begin
                    cur_ceil_next = meta_rdata.ceil;
                end
                state_next = ret_reg;
            end

            // Queue page pg at the back of list k.
            bpa_pkg::S_PB:
            begin
                lt         = tail_reg[k_reg[KW-1:0]];
                nx_we      = 1'b1;
                nx_wdata   = LNULL;
                pv_we      = 1'b1;
                pv_wdata   = lt;
                meta_we    = 1'b1;
                tail_next[k_reg[KW-1:0]] = LW'(pg_reg);
                if (lt < LNULL)
                begin
                    t_next     = lt;
                    state_next = bpa_pkg::S_PB2;
                end
                else
                begin
                    head_next[k_reg[KW-1:0]] = LW'(pg_reg);
                    state_next = ret_reg;
                end
            end

            bpa_pkg::S_PB2:
            begin
                nx_we      = 1'b1;
                nx_waddr   = t_reg[PW-1:0];
                nx_wdata   = LW'(pg_reg);
                state_next = ret_reg;
            end

            // Queue page pg at the front of list k; this ends a free request.
            bpa_pkg::S_PF:
            begin
                lt         = head_reg[k_reg[KW-1:0]];
                nx_we      = 1'b1;
                nx_wdata   = lt;
                pv_we      = 1'b1;
                pv_wdata   = LNULL;
                meta_we    = 1'b1;
                head_next[k_reg[KW-1:0]] = LW'(pg_reg);
                res_status_next = bpa_pkg::STAT_OK;
                if (lt < LNULL)
                begin
                    t_next     = lt;
                    state_next = bpa_pkg::S_PF2;
                end
                else
                begin
                    tail_next[k_reg[KW-1:0]] = LW'(pg_reg);
                    state_next = bpa_pkg::S_DONE;
                end
            end

            bpa_pkg::S_PF2:
            begin
                pv_we      = 1'b1;
                pv_waddr   = t_reg[PW-1:0];
                pv_wdata   = LW'(pg_reg);
                state_next = bpa_pkg::S_DONE;
            end

            bpa_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = bpa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bpa_pkg::S_IDLE;
            end
        endcase
    end

    // Link memories are never written while the metadata sweep runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bpa_pkg::S_CLEAR) |-> (!nx_we && !pv_we))
    else $error("link memory written during the clearing sweep");

    // Every accepted request leaves the idle state on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != bpa_pkg::S_IDLE))
    else $error("accepted request did not start");

    // Each free list is either empty at both ends or at neither.
    for (genvar g = 0; g < NUM_ORDERS; g++)
    begin : g_list_chk
        assert property (@(posedge clk) disable iff (!rst_n)
            (state_reg == bpa_pkg::S_IDLE) |->
                ((head_reg[g] == LNULL) == (tail_reg[g] == LNULL)))
        else $error("free list head and tail disagree on emptiness");
    end

endmodule

// ===== tb/sv/tb_buddy_page_allocator_core.sv =====
// Self-checking bench for buddy_page_allocator_core: add, allocate and free requests on the
// stream input, responses compared against a behavioral buddy allocator kept in this file.
// Depends on bpa_pkg and the allocator RTL.
module tb_buddy_page_allocator_core;

    localparam int NPAGES  = bpa_pkg::NUM_PAGES_DEF;
    localparam int NORDERS = bpa_pkg::NUM_ORDERS_DEF;
    localparam int NIL     = NPAGES;
    localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [12:0] end_page;
        logic [11:0] first_page;
        logic [3:0]  order;
        logic [1:0]  func;
    } alloc_req_t;

    typedef struct packed {
        logic [11:0] head_pg;
        logic [1:0]  status;
    } alloc_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        s_axis_tready_seen;

    buddy_page_allocator_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Shadow copy of the allocator's bookkeeping.
    bit  pg_free [NPAGES];
    int  pg_order[NPAGES];
    int  pg_ceil [NPAGES];
    int  nxt     [NPAGES];
    int  prv     [NPAGES];
    int  head    [NORDERS];
    int  tail    [NORDERS];

    alloc_req_t pending_reqs[$];
    alloc_rsp_t expected_rsps[$];
    int  held_blocks[$];   // heads of blocks currently allocated, for realistic frees
    int  errors = 0;
    int  rsp_count = 0;
    int  n_ok = 0, n_oom = 0, n_bad = 0;
    longint cycles = 0;
    bit  calm = 0;         // when set, neither side idles
    bit  stim_done = 0;

    function automatic void list_append(int k, int p);
        nxt[p] = NIL;
        prv[p] = tail[k];
        if (tail[k] < NIL) nxt[tail[k]] = p;
        else head[k] = p;
        tail[k] = p;
        pg_free[p] = 1;
        pg_order[p] = k;
    endfunction

    function automatic void list_prepend(int k, int p);
        prv[p] = NIL;
        nxt[p] = head[k];
        if (head[k] < NIL) prv[head[k]] = p;
        else tail[k] = p;
        head[k] = p;
        pg_free[p] = 1;
        pg_order[p] = k;
    endfunction

    function automatic void list_unlink(int k, int p);
        if (prv[p] < NIL) nxt[prv[p]] = nxt[p];
        else head[k] = nxt[p];
        if (nxt[p] < NIL) prv[nxt[p]] = prv[p];
        else tail[k] = prv[p];
        pg_free[p] = 0;
    endfunction

    // Applies one request to the shadow state and returns the response it should produce.
    function automatic alloc_rsp_t predict_response(alloc_req_t r);
        alloc_rsp_t rsp;
        int base, lim, k, sz, p, b, want;
        rsp = '0;
        case (r.func)
            bpa_pkg::FUNC_ADD:
            begin
                base = r.first_page;
                lim = (r.end_page > NPAGES) ? NPAGES : r.end_page;
                while (base < lim)
                begin
                    k = 0;
                    while (k + 1 < NORDERS)
                    begin
                        sz = 1 << (k + 1);
                        if (base + sz > lim || (base & (sz - 1)) != 0) break;
                        k++;
                    end
                    if (!pg_free[base])
                    begin
                        pg_ceil[base] = k;
                        list_append(k, base);
                    end
                    base += 1 << k;
                end
                rsp.status = bpa_pkg::STAT_OK;
            end
            bpa_pkg::FUNC_ALLOC:
            begin
                want = r.order;
                if (want >= NORDERS) rsp.status = bpa_pkg::STAT_BAD;
                else
                begin
                    k = want;
                    while (k < NORDERS && head[k] >= NIL) k++;
                    if (k >= NORDERS) rsp.status = bpa_pkg::STAT_OOM;
                    else
                    begin
                        p = head[k];
                        list_unlink(k, p);
                        while (k != want)
                        begin
                            k--;
                            b = p + (1 << k);
                            if (b < NPAGES && !pg_free[b])
                            begin
                                pg_ceil[b] = pg_ceil[p];
                                list_append(k, b);
                            end
                        end
                        pg_order[p] = want;
                        rsp.status = bpa_pkg::STAT_OK;
                        rsp.head_pg = p[11:0];
                        held_blocks.insert(held_blocks.size(), p);
                    end
                end
            end
            bpa_pkg::FUNC_FREE:
            begin
                p = r.first_page;
                if (pg_free[p]) rsp.status = bpa_pkg::STAT_BAD;
                else
                begin
                    k = pg_order[p];
                    if (k >= NORDERS) k = NORDERS - 1;
                    while (k < pg_ceil[p] && k + 1 < NORDERS)
                    begin
                        b = p ^ (1 << k);
                        if (b >= NPAGES || !pg_free[b] || pg_order[b] != k) break;
                        list_unlink(k, b);
                        if (b < p) p = b;
                        k++;
                        pg_order[p] = k;
                    end
                    list_prepend(k, p);
                    rsp.status = bpa_pkg::STAT_OK;
                end
            end
            default: rsp.status = bpa_pkg::STAT_BAD;
        endcase
        return rsp;
    endfunction

    function automatic alloc_req_t make_req(logic [1:0] f, int ord, int first, int last);
        alloc_req_t r;
        r.func = f;
        r.order = ord[3:0];
        r.first_page = first[11:0];
        r.end_page = last[12:0];
        return r;
    endfunction

    // Appends one request to the list of pending requests.
    function automatic void queue_req(alloc_req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    // Picks a free target: mostly a block we hold, sometimes any page (stray or double free).
    // The shadow is consulted when the request is generated, so a held block may have been
    // freed already; that simply becomes a bad-free case.
    function automatic int pick_free_page();
        int i, p;
        if (held_blocks.size() > 0 && $urandom_range(0, 9) < 8)
        begin
            i = $urandom_range(0, held_blocks.size() - 1);
            p = held_blocks[i];
            held_blocks.delete(i);
            return p;
        end
        return $urandom_range(0, NPAGES - 1);
    endfunction

    always #1 clk = ~clk;

    // Predictor: the shadow model runs here, at acceptance, so requests are predicted in order.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_rsps.insert(expected_rsps.size(),
                                 predict_response(alloc_req_t'(s_axis_tdata[30:0])));
    end

    // Driver: a request stays on the bus until taken, then the next one may follow.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || s_axis_tready_seen)
            begin
                if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 22))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {1'b0, pending_reqs[0]};
                    pending_reqs.delete(0);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 22);
        end
    end

    // Records whether the request on the bus was taken at the last rising edge.
    always @(posedge clk)
        s_axis_tready_seen <= s_axis_tvalid && s_axis_tready;

    // Monitor: compares every response with the oldest prediction.
    always @(posedge clk)
    begin
        alloc_rsp_t got, exp_rsp;
        cycles <= cycles + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = alloc_rsp_t'(m_axis_tdata[13:0]);
            rsp_count <= rsp_count + 1;
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: response expected none actual status=%0d page=%0d", $time,
                         got.status, got.head_pg);
                errors++;
            end
            else
            begin
                exp_rsp = expected_rsps[0];
                expected_rsps.delete(0);
                if (got.status !== exp_rsp.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_rsp.status, got.status);
                    errors++;
                end
                if (got.head_pg !== exp_rsp.head_pg)
                begin
                    $display("%0t: head page expected %0d actual %0d", $time,
                             exp_rsp.head_pg, got.head_pg);
                    errors++;
                end
                case (exp_rsp.status)
                    bpa_pkg::STAT_OK:  n_ok++;
                    bpa_pkg::STAT_OOM: n_oom++;
                    default:           n_bad++;
                endcase
            end
        end
    end

    // Stimulus generation. Requests are queued ahead; held_blocks tracks what the model
    // handed out so far, which is only exact once the driver has caught up, so batches are
    // generated and drained in turn.
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || s_axis_tvalid)
            @(posedge clk);
    endtask

    task automatic queue_random_batch(int n);
        int i, sel, a, len;
        for (i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 6)
            begin
                // Region adds, small mostly, sometimes huge or inverted.
                a = $urandom_range(0, NPAGES - 1);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                                   : $urandom_range(0, 300);
                queue_req(make_req(bpa_pkg::FUNC_ADD, 0, a,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                                : ((a + len > 8191) ? 8191 : a + len)));
            end
            else if (sel < 50)
                queue_req(make_req(bpa_pkg::FUNC_ALLOC,
                    ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(0, 4), 0, 0));
            else if (sel < 97)
                queue_req(make_req(bpa_pkg::FUNC_FREE, 0, pick_free_page(), 0));
            else
                queue_req(make_req(FUNC_UNKNOWN, $urandom_range(0, 15),
                    $urandom_range(0, NPAGES - 1), $urandom_range(0, 8191)));
        end
    endtask

    initial
    begin
        int b;
        clk = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        s_axis_tready_seen = 0;
        for (int i = 0; i < NPAGES; i++)
        begin
            pg_free[i] = 0; pg_order[i] = 0; pg_ceil[i] = 0; nxt[i] = NIL; prv[i] = NIL;
        end
        for (int k = 0; k < NORDERS; k++)
        begin
            head[k] = NIL; tail[k] = NIL;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: empty pool, bad orders, unknown function, bad free targets, ranges.
        queue_req(make_req(bpa_pkg::FUNC_ALLOC, 0, 0, 0));           // nothing free
        queue_req(make_req(bpa_pkg::FUNC_ALLOC, 15, 0, 0));          // bad order
        queue_req(make_req(bpa_pkg::FUNC_ALLOC, NORDERS, 0, 0));
        queue_req(make_req(FUNC_UNKNOWN, 15, 4095, 8191));
        queue_req(make_req(bpa_pkg::FUNC_ADD, 0, 100, 50));           // inverted region
        queue_req(make_req(bpa_pkg::FUNC_ADD, 0, 3, 3));              // empty region
        queue_req(make_req(bpa_pkg::FUNC_ADD, 0, 4090, 8191));        // saturated end
        queue_req(make_req(bpa_pkg::FUNC_ADD, 0, 4092, 4096));        // overlapping add
        queue_req(make_req(bpa_pkg::FUNC_ADD, 0, 0, 4096));           // whole pool
        queue_req(make_req(bpa_pkg::FUNC_ALLOC, 10, 0, 0));
        queue_req(make_req(bpa_pkg::FUNC_ALLOC, 0, 0, 0));            // splits a free order-1 block
        queue_req(make_req(bpa_pkg::FUNC_ALLOC, 1, 0, 0));
        queue_req(make_req(bpa_pkg::FUNC_FREE, 0, 0, 0));             // frees the order-10 block at page 0
        queue_req(make_req(bpa_pkg::FUNC_FREE, 0, 0, 0));             // already free
        queue_req(make_req(bpa_pkg::FUNC_FREE, 0, 4095, 0));          // stray, last page
        queue_req(make_req(bpa_pkg::FUNC_FREE, 0, 1024, 0));
        queue_req(make_req(bpa_pkg::FUNC_ALLOC, 10, 0, 0));
        queue_req(make_req(bpa_pkg::FUNC_ALLOC, 10, 0, 0));
        queue_req(make_req(bpa_pkg::FUNC_ALLOC, 10, 0, 0));
        queue_req(make_req(bpa_pkg::FUNC_ALLOC, 10, 0, 0));           // takes the last free order-10 block
        queue_req(make_req(bpa_pkg::FUNC_FREE, 0, 2048, 0));
        calm = 1;
        wait_drained();
        calm = 0;

        // Random part in batches so that frees target blocks actually held.
        for (b = 0; b < 26; b++)
        begin
            calm = (b >= 8 && b < 11);
            queue_random_batch(50);
            wait_drained();
        end
        calm = 0;
        stim_done = 1;
    end

    // End of run and watchdog.
    initial
    begin
        wait (stim_done);
        repeat (200) @(posedge clk);
        $display("Covered %0d responses: %0d ok, %0d out of memory, %0d bad request.",
                 rsp_count, n_ok, n_oom, n_bad);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d responses outstanding.",
                     cycles, expected_rsps.size());
            $display("status: fail");
            $finish;
        end
    end
endmodule

// ===== buddy_page_allocator_core.f =====
design/bpa_pkg.sv
design/bpa_ram.sv
design/buddy_page_allocator_core.sv
tb/sv/tb_buddy_page_allocator_core.sv
